// ===== rtl/core/fqrc_pkg.sv =====
// Package for the queue with reverse and clone.
// Holds operation, status and sequencer codes and the result record.
// No dependencies.
package fqrc_pkg;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_REVERSE = 2'd2,
    OP_CLONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DQ_CAP,
    S_CL_RD,
    S_CL_WR,
    S_FRONT,
    S_FRONT_CAP
  } state_e;

  localparam int unsigned ValueWidth = 32;

  typedef struct packed {
    logic [ValueWidth-1:0] removed_value;
    status_e               status;
  } res_t;

endpackage

// ===== rtl/core/fqrc_store.sv =====
// Entry store of the queue: one write port, one read port, registered read data.
// Depends on fqrc_pkg for the value width.
module fqrc_store #(
  parameter int unsigned Depth = 16,
  parameter int unsigned PtrWidth = 4
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [PtrWidth-1:0]           waddr_i,
  input  logic [fqrc_pkg::ValueWidth-1:0] wdata_i,
  input  logic [PtrWidth-1:0]           raddr_i,
  output logic [fqrc_pkg::ValueWidth-1:0] rdata_o
);
  import fqrc_pkg::*;

  logic [ValueWidth-1:0] mem [Depth];
  logic [ValueWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/fqrc_ctrl.sv =====
// Sequencer of the queue: head pointer, count, direction bit and the clone copy loop.
// Drives the entry store ports and hands a result record to the output stage.
// Depends on fqrc_pkg.
module fqrc_ctrl #(
  parameter int unsigned Depth = 16,
  parameter int unsigned PtrWidth = 4,
  parameter int unsigned CntWidth = 5
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  fqrc_pkg::op_e                   in_op_i,
  input  logic [fqrc_pkg::ValueWidth-1:0] in_value_i,
  input  logic                            out_free_i,
  output logic                            res_load_o,
  output fqrc_pkg::res_t                  res_o,
  output logic [CntWidth-1:0]             count_o,
  output logic                            mem_we_o,
  output logic [PtrWidth-1:0]             mem_waddr_o,
  output logic [fqrc_pkg::ValueWidth-1:0] mem_wdata_o,
  output logic [PtrWidth-1:0]             mem_raddr_o,
  input  logic [fqrc_pkg::ValueWidth-1:0] mem_rdata_i
);
  import fqrc_pkg::*;

  function automatic logic [PtrWidth-1:0] ptr_inc(input logic [PtrWidth-1:0] p);
    logic [PtrWidth-1:0] r;
    if (p == PtrWidth'(Depth - 1)) r = '0;
    else r = p + PtrWidth'(1);
    return r;
  endfunction

  function automatic logic [PtrWidth-1:0] ptr_dec(input logic [PtrWidth-1:0] p);
    logic [PtrWidth-1:0] r;
    if (p == '0) r = PtrWidth'(Depth - 1);
    else r = p - PtrWidth'(1);
    return r;
  endfunction

  function automatic logic [PtrWidth-1:0] ptr_add(input logic [PtrWidth-1:0] p,
                                                  input logic [CntWidth-1:0] c);
    logic [CntWidth:0] s;
    s = (CntWidth+1)'(p) + (CntWidth+1)'(c);
    if (s >= (CntWidth+1)'(Depth)) s = s - (CntWidth+1)'(Depth);
    return s[PtrWidth-1:0];
  endfunction

  state_e                state_q, state_d;
  logic [PtrWidth-1:0]   head_q, head_d;
  logic [CntWidth-1:0]   count_q, count_d;
  logic                  rev_q, rev_d;
  logic [PtrWidth-1:0]   rp_q, rp_d;
  logic [PtrWidth-1:0]   wp_q, wp_d;
  logic [CntWidth-1:0]   rem_q, rem_d;
  res_t                  res_q, res_d;
  logic [PtrWidth-1:0]   front_slot;
  logic [PtrWidth-1:0]   last_slot;
  logic                  is_empty;
  logic                  is_full;

  assign last_slot  = ptr_add(head_q, count_q - CntWidth'(1));
  assign front_slot = rev_q ? last_slot : head_q;
  assign is_empty   = (count_q == '0);
  assign is_full    = (count_q >= CntWidth'(Depth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      rev_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      rev_q   <= rev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rp_q  <= rp_d;
    wp_q  <= wp_d;
    rem_q <= rem_d;
    res_q <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    rev_d       = rev_q;
    rp_d        = rp_q;
    wp_d        = wp_q;
    rem_d       = rem_q;
    res_d       = res_q;
    in_ready_o  = 1'b0;
    res_load_o  = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = wp_q;
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = front_slot;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          res_d.removed_value = '0;
          res_d.status        = STAT_DONE;
          state_d             = S_FRONT;
          case (in_op_i)
            OP_ENQUEUE: begin
              if (is_full) begin
                res_d.status = STAT_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_wdata_o = in_value_i;
                count_d     = count_q + CntWidth'(1);
                if (rev_q) begin
                  mem_waddr_o = ptr_dec(head_q);
                  head_d      = ptr_dec(head_q);
                end else begin
                  mem_waddr_o = ptr_add(head_q, count_q);
                end
              end
            end
            OP_DEQUEUE: begin
              if (is_empty) begin
                res_d.status = STAT_EMPTY;
              end else begin
                count_d = count_q - CntWidth'(1);
                if (!rev_q) head_d = ptr_inc(head_q);
                state_d = S_DQ_CAP;
              end
            end
            OP_REVERSE: begin
              if (is_empty) res_d.status = STAT_EMPTY;
              else rev_d = ~rev_q;
            end
            OP_CLONE: begin
              if (is_empty) begin
                res_d.status = STAT_EMPTY;
              end else if (count_q > CntWidth'(Depth) - count_q) begin
                res_d.status = STAT_FULL;
              end else begin
                rem_d   = count_q;
                rp_d    = front_slot;
                wp_d    = rev_q ? ptr_dec(head_q) : ptr_add(head_q, count_q);
                state_d = S_CL_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_DQ_CAP: begin
        res_d.removed_value = mem_rdata_i;
        state_d             = S_FRONT;
      end
      S_CL_RD: begin
        mem_raddr_o = rp_q;
        state_d     = S_CL_WR;
      end
      S_CL_WR: begin
        mem_we_o = 1'b1;
        count_d  = count_q + CntWidth'(1);
        rem_d    = rem_q - CntWidth'(1);
        if (rev_q) begin
          head_d = wp_q;
          rp_d   = ptr_dec(rp_q);
          wp_d   = ptr_dec(wp_q);
        end else begin
          rp_d = ptr_inc(rp_q);
          wp_d = ptr_inc(wp_q);
        end
        if (rem_q == CntWidth'(1)) state_d = S_FRONT;
        else state_d = S_CL_RD;
      end
      S_FRONT: begin
        state_d = S_FRONT_CAP;
      end
      S_FRONT_CAP: begin
        if (out_free_i) begin
          res_load_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o   = res_q;
  assign count_o = count_q;

endmodule

// ===== rtl/core/fifo_queue_reverse_clone_unit.sv =====
// Top level of the bounded queue with reverse and clone.
// Instantiates fqrc_ctrl and fqrc_store, holds the result register; uses fqrc_pkg.
//
// Input channel s_axis: tuser carries the operation (enqueue, dequeue, reverse,
// clone), tdata the value appended on enqueue. Output channel m_axis: one
// transaction per accepted input with removed value, front value, front valid,
// entry count and status.
// After acceptance, enqueue, reverse and refused operations pass S_FRONT and
// S_FRONT_CAP before the result is valid; dequeue first passes S_DQ_CAP, and a
// clone of N entries first passes S_CL_RD and S_CL_WR once for each entry.
// A new transaction is taken only after the previous result has been loaded.
// The block takes one transaction at a time; s_axis_tready_o is high only while
// the sequencer is idle. The store has one write and one read port with a
// registered read, so the front value is read back through S_FRONT and
// S_FRONT_CAP, and a clone copies each entry through a read and a write state.
// Reset empties the queue and restores normal order; store contents are not
// cleared and never show. When the receiver stalls, the result register holds
// its transaction and the sequencer waits before loading the next one.
module fifo_queue_reverse_clone_unit #(
  parameter int unsigned QUEUE_DEPTH = 16,
  localparam int unsigned CntWidth = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [31:0] new_value
  input  logic [31:0]         s_axis_tdata_i,
  // [1:0] operation
  input  logic [1:0]          s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [31:0] removed_value, [63:32] front_value, [64] front_valid,
  // [64+CntWidth:65] entry_count, next 2 bits status, zero padded to bytes
  output logic [((2*32+1+CntWidth+2+7)/8)*8-1:0] m_axis_tdata_o
);
  import fqrc_pkg::*;

  localparam int unsigned PtrWidth  = $clog2(QUEUE_DEPTH);
  localparam int unsigned DataBits  = 2 * ValueWidth + 1 + CntWidth + 2;
  localparam int unsigned OutWidth  = ((DataBits + 7) / 8) * 8;
  localparam int unsigned CntLsb    = 2 * ValueWidth + 1;
  localparam int unsigned StatLsb   = CntLsb + CntWidth;

  logic                  res_load;
  res_t                  res;
  logic [CntWidth-1:0]   count;
  logic                  mem_we;
  logic [PtrWidth-1:0]   mem_waddr;
  logic [ValueWidth-1:0] mem_wdata;
  logic [PtrWidth-1:0]   mem_raddr;
  logic [ValueWidth-1:0] mem_rdata;
  logic                  out_valid_q, out_valid_d;
  logic [OutWidth-1:0]   out_data_q, out_data_d;
  logic                  out_free;

  assign out_free = !out_valid_q || m_axis_tready_i;

  fqrc_ctrl #(
    .Depth    (QUEUE_DEPTH),
    .PtrWidth (PtrWidth),
    .CntWidth (CntWidth)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_op_i     (op_e'(s_axis_tuser_i)),
    .in_value_i  (s_axis_tdata_i),
    .out_free_i  (out_free),
    .res_load_o  (res_load),
    .res_o       (res),
    .count_o     (count),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  fqrc_store #(
    .Depth    (QUEUE_DEPTH),
    .PtrWidth (PtrWidth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (m_axis_tready_i) out_valid_d = 1'b0;
    if (res_load) begin
      out_valid_d = 1'b1;
      out_data_d  = '0;
      out_data_d[ValueWidth-1:0]            = res.removed_value;
      out_data_d[2*ValueWidth-1:ValueWidth] = (count != '0) ? mem_rdata : '0;
      out_data_d[2*ValueWidth]              = (count != '0);
      out_data_d[CntLsb +: CntWidth]        = count;
      out_data_d[StatLsb +: 2]              = res.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ===== tb/tb.sv =====
// Testbench for fifo_queue_reverse_clone_unit: drives queue operations on s_axis
// and checks every m_axis result against an in-bench model of the queue.
// Depends on fqrc_pkg and the unit RTL.
module tb;
  import fqrc_pkg::*;

  localparam int unsigned QDepth = 16;
  localparam int unsigned CntW   = $clog2(QDepth + 1);
  localparam int unsigned OutW   = ((2*32+1+CntW+2+7)/8)*8;

  typedef struct packed {
    logic [31:0]     removed;
    logic [31:0]     front;
    logic            valid;
    logic [CntW-1:0] count;
    logic [1:0]      status;
  } queue_view_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready_o;
  logic [31:0]     s_axis_tdata = '0;
  logic [1:0]      s_axis_tuser = OP_ENQUEUE;
  logic            m_axis_tvalid_o;
  logic            m_axis_tready = 1'b0;
  logic [OutW-1:0] m_axis_tdata_o;

  logic [31:0]     model_store [QDepth];
  int unsigned     model_head;
  int unsigned     model_count;
  logic            model_rev;

  queue_view_t     predicted_views [$];
  int              errors = 0;
  bit              tx_burst = 1'b0;
  bit              rx_burst = 1'b0;
  int unsigned     rx_hold_len = 0;

  fifo_queue_reverse_clone_unit #(
    .QUEUE_DEPTH(QDepth)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o,
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o,
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned slot_at(int unsigned pos);
    if (model_rev) begin
      return (model_head + model_count - 1 - pos) % QDepth;
    end
    return (model_head + pos) % QDepth;
  endfunction

  function automatic void push_rear(logic [31:0] value);
    if (model_rev) begin
      model_head = (model_head + QDepth - 1) % QDepth;
      model_store[model_head] = value;
    end else begin
      model_store[(model_head + model_count) % QDepth] = value;
    end
    model_count++;
  endfunction

  function automatic queue_view_t predict_queue_op(op_e op, logic [31:0] value);
    queue_view_t view;
    int unsigned n;
    view = '0;
    view.status = STAT_DONE;
    case (op)
      OP_ENQUEUE: begin
        if (model_count >= QDepth) view.status = STAT_FULL;
        else push_rear(value);
      end
      OP_DEQUEUE: begin
        if (model_count == 0) begin
          view.status = STAT_EMPTY;
        end else begin
          view.removed = model_store[slot_at(0)];
          if (!model_rev) model_head = (model_head + 1) % QDepth;
          model_count--;
        end
      end
      OP_REVERSE: begin
        if (model_count == 0) view.status = STAT_EMPTY;
        else model_rev = ~model_rev;
      end
      default: begin
        n = model_count;
        if (n == 0) begin
          view.status = STAT_EMPTY;
        end else if (n > QDepth - n) begin
          view.status = STAT_FULL;
        end else begin
          for (int unsigned i = 0; i < n; i++) push_rear(model_store[slot_at(i)]);
        end
      end
    endcase
    view.valid = (model_count != 0);
    view.front = view.valid ? model_store[slot_at(0)] : '0;
    view.count = CntW'(model_count);
    return view;
  endfunction

  task automatic send_op(input op_e op, input logic [31:0] value);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted_views.push_back(predict_queue_op(op, value));
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (predicted_views.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    queue_view_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready) begin
      if (predicted_views.size() == 0) begin
        $display("%0t: result expected none got %h", $time, m_axis_tdata_o);
        errors++;
      end else begin
        want = predicted_views.pop_front();
        check_field("removed_value", want.removed, m_axis_tdata_o[31:0]);
        check_field("front_value", want.front, m_axis_tdata_o[63:32]);
        check_field("front_valid", 32'(want.valid), 32'(m_axis_tdata_o[64]));
        check_field("entry_count", 32'(want.count), 32'(m_axis_tdata_o[64+CntW:65]));
        check_field("status", 32'(want.status), 32'(m_axis_tdata_o[66+CntW:65+CntW]));
        check_field("padding", '0, 32'(m_axis_tdata_o >> (67 + CntW)));
      end
    end
  end

  initial begin : receiver
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_len != 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold_len) @(posedge clk_i);
        rx_hold_len = 0;
      end
      gap = rx_burst ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  task automatic test_empty_queue();
    send_op(OP_DEQUEUE, $urandom());
    send_op(OP_REVERSE, $urandom());
    send_op(OP_CLONE, $urandom());
    wait_drain();
  endtask

  task automatic test_value_extremes();
    send_op(OP_ENQUEUE, 32'h8000_0000);
    send_op(OP_ENQUEUE, 32'h7fff_ffff);
    send_op(OP_ENQUEUE, 32'h0000_0000);
    send_op(OP_ENQUEUE, 32'hffff_ffff);
    send_op(OP_DEQUEUE, 32'hffff_ffff);
    send_op(OP_DEQUEUE, 32'h0000_0000);
    wait_drain();
  endtask

  task automatic test_reverse_clone_full();
    send_op(OP_REVERSE, $urandom());
    send_op(OP_DEQUEUE, $urandom());
    send_op(OP_REVERSE, $urandom());
    repeat (4) send_op(OP_CLONE, $urandom());
    send_op(OP_ENQUEUE, 32'h1234_5678);
    send_op(OP_CLONE, $urandom());
    send_op(OP_DEQUEUE, $urandom());
    send_op(OP_REVERSE, $urandom());
    send_op(OP_CLONE, $urandom());
    wait_drain();
  endtask

  task automatic test_random_mix(input int unsigned items);
    int unsigned mode;
    int unsigned roll;
    op_e op;
    for (int unsigned i = 0; i < items; i++) begin
      if (i % 50 == 0) begin
        mode     = $urandom_range(0, 2);
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_burst = ($urandom_range(0, 3) == 0);
      end
      roll = $urandom_range(0, 99);
      case (mode)
        0:       op = (roll < 55) ? OP_ENQUEUE : (roll < 70) ? OP_DEQUEUE :
                      (roll < 82) ? OP_REVERSE : OP_CLONE;
        1:       op = (roll < 20) ? OP_ENQUEUE : (roll < 75) ? OP_DEQUEUE :
                      (roll < 88) ? OP_REVERSE : OP_CLONE;
        default: op = op_e'(roll % 4);
      endcase
      send_op(op, pick_value());
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    wait_drain();
  endtask

  task automatic test_backpressure();
    rx_hold_len = 200;
    tx_burst    = 1'b1;
    repeat (12) send_op(op_e'($urandom_range(0, 3)), pick_value());
    tx_burst = 1'b0;
    wait_drain();
  endtask

  initial begin
    model_head  = 0;
    model_count = 0;
    model_rev   = 1'b0;
    for (int unsigned i = 0; i < QDepth; i++) model_store[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_queue();
    test_value_extremes();
    test_reverse_clone_full();
    test_backpressure();
    test_random_mix(1380);
    wait_drain();
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/fqrc_pkg.sv
rtl/core/fqrc_store.sv
rtl/core/fqrc_ctrl.sv
rtl/core/fifo_queue_reverse_clone_unit.sv
tb/tb.sv
